### hw/rtl/iof_pkg.sv
// Shared types, register codes and sizes for the IMU orientation filter.
`timescale 1ns / 1ps
package iof_pkg;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int RootSteps  = 32;
  localparam int RootCntW   = $clog2(RootSteps);
  localparam int DivSteps   = 31;
  localparam int DivCntW    = $clog2(DivSteps);

  typedef enum logic [2:0] {
    REG_GYRO_OFFSET_X,
    REG_GYRO_OFFSET_Y,
    REG_GYRO_OFFSET_Z,
    REG_RATE_DEADBAND,
    REG_CORRECTION_GAIN,
    REG_SMOOTHING_WEIGHT,
    REG_STEP_TIME
  } iof_reg_e;

  typedef struct packed {
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] off_z;
    logic [14:0]        deadband;
    logic [15:0]        beta;
    logic [16:0]        weight;
    logic [15:0]        dt;
  } iof_cfg_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] rz;
    logic               held;
  } iof_item_t;

endpackage

### hw/rtl/iof_front.sv
// Front end: takes a sample, removes gyro bias, applies deadband, flags static items.
`timescale 1ns / 1ps
module iof_front import iof_pkg::*; (
  input  iof_cfg_t           cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output iof_item_t          push_item_o
);

  logic signed [16:0] rate_raw [3];
  logic signed [16:0] rate_cut [3];
  logic [16:0]        rate_mag [3];

  always_comb begin
    rate_raw[0] = 17'(rate_x_i) - 17'(cfg_i.off_x);
    rate_raw[1] = 17'(rate_y_i) - 17'(cfg_i.off_y);
    rate_raw[2] = 17'(rate_z_i) - 17'(cfg_i.off_z);
    for (int i = 0; i < 3; i++) begin
      rate_mag[i] = rate_raw[i][16] ? 17'(-rate_raw[i]) : 17'(rate_raw[i]);
      rate_cut[i] = (rate_mag[i] < {2'b00, cfg_i.deadband}) ? 17'sd0 : rate_raw[i];
    end
  end

  always_comb begin
    push_item_o.ax   = accel_x_i;
    push_item_o.ay   = accel_y_i;
    push_item_o.az   = accel_z_i;
    push_item_o.rx   = rate_cut[0];
    push_item_o.ry   = rate_cut[1];
    push_item_o.rz   = rate_cut[2];
    push_item_o.held = (rate_cut[0] == 17'sd0) && (rate_cut[1] == 17'sd0) &&
                       (rate_cut[2] == 17'sd0);
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

endmodule

### hw/rtl/iof_queue.sv
// Small item queue between the front end and the filter engine.
`timescale 1ns / 1ps
module iof_queue import iof_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  iof_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output iof_item_t pop_item_o
);

  iof_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q;
  logic [QueuePtrW-1:0]  rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q;
  logic                  push;
  logic                  pop;

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/iof_root.sv
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module iof_root import iof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic                busy_q;
  logic                done_q;
  logic [RootCntW-1:0] cnt_q;
  logic [63:0]         rem_q;
  logic [63:0]         res_q;
  logic [63:0]         bit_w;
  logic [64:0]         try_w;

  assign bit_w  = 64'd1 << {cnt_q, 1'b0};
  assign try_w  = {1'b0, res_q} + {1'b0, bit_w};
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= RootCntW'(RootSteps - 1);
        rem_q  <= rad_i;
        res_q  <= '0;
      end else if (busy_q) begin
        if ({1'b0, rem_q} >= try_w) begin
          rem_q <= rem_q - try_w[63:0];
          res_q <= (res_q >> 1) + bit_w;
        end else begin
          res_q <= res_q >> 1;
        end
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/iof_div.sv
// Unit-vector divider: magnitude times 2^30 over the norm, one quotient bit per cycle.
`timescale 1ns / 1ps
module iof_div import iof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [30:0] quo_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [32:0]        rem_q;
  logic [31:0]        den_q;
  logic [30:0]        quo_q;
  logic               ge_w;
  logic [32:0]        left_w;

  assign ge_w   = rem_q >= {1'b0, den_q};
  assign left_w = ge_w ? rem_q - {1'b0, den_q} : rem_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps - 1);
        rem_q  <= {1'b0, num_i};
        den_q  <= den_i;
        quo_q  <= '0;
      end else if (busy_q) begin
        quo_q <= {quo_q[29:0], ge_w};
        rem_q <= {left_w[31:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/iof_back.sv
// Filter engine: low-pass, gradient step, integration and renormalization on shared units.
`timescale 1ns / 1ps
module iof_back import iof_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iof_cfg_t           cfg_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  iof_item_t          item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] quat_w_o,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic               held_static_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LP, ST_ASUM, ST_ASQRT, ST_ADIV, ST_F, ST_G, ST_GSUM, ST_GSQRT,
    ST_GDIV, ST_QD, ST_BG, ST_DT, ST_HALVE, ST_QSUM, ST_QSQRT, ST_QDIV, ST_OUT
  } state_e;

  localparam logic signed [38:0] Lim39 = 39'sd2147483648;
  localparam logic signed [32:0] Lim33 = 33'sd2147483648;

  function automatic logic signed [32:0] clamp_op(input logic signed [38:0] x);
    if (x > Lim39) begin
      return Lim33;
    end else if (x < -Lim39) begin
      return -Lim33;
    end
    return 33'(x);
  endfunction

  state_e             state_q;
  logic [3:0]         k_q;
  logic               ph_q;
  iof_item_t          item_q;
  logic signed [23:0] sm_q  [3];
  logic signed [31:0] att_q [4];
  logic signed [31:0] av_q  [3];
  logic signed [35:0] f_q   [3];
  logic signed [31:0] g_q   [4];
  logic signed [37:0] qd_q  [4];
  logic signed [38:0] qn_q  [4];
  logic [31:0]        nrm_q;
  logic signed [66:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [54:0] prod_dt_q;
  logic               out_valid_q;
  logic signed [31:0] out_q [4];
  logic               out_held_q;

  logic signed [38:0] att_x [4];
  logic signed [38:0] tq_x  [4];
  logic signed [38:0] f_x   [3];
  logic signed [38:0] sm_x  [3];
  logic signed [38:0] g_x   [4];
  logic signed [38:0] qn_x  [4];
  logic signed [38:0] rt_x  [3];
  logic signed [38:0] tg_x  [3];
  logic signed [38:0] wc_x;
  logic signed [38:0] beta_x;

  logic [1:0]         kk;
  logic signed [38:0] op_a_raw;
  logic signed [38:0] op_b_raw;
  logic [5:0]         sh;
  logic               neg;
  logic               first;
  logic               last;
  logic [1:0]         dst;
  logic signed [38:0] fin;
  logic [3:0]         k_last;
  state_e             nxt;

  logic signed [65:0] mul_p;
  logic signed [54:0] dt_p;
  logic signed [65:0] term;
  logic signed [66:0] acc_n;
  logic               q_big;
  logic signed [38:0] dv_v;
  logic signed [38:0] dv_mag;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic               dv_start;
  logic               dv_done;
  logic [30:0]        dv_quo;
  logic signed [31:0] dv_res;
  logic               in_div;

  assign kk = k_q[1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      att_x[i] = 39'(att_q[i]);
      tq_x[i]  = 39'(att_q[i]) <<< 1;
      g_x[i]   = 39'(g_q[i]);
      qn_x[i]  = qn_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      f_x[i]  = 39'(f_q[i]);
      sm_x[i] = 39'(sm_q[i]);
    end
    rt_x[0] = 39'(item_q.rx);
    rt_x[1] = 39'(item_q.ry);
    rt_x[2] = 39'(item_q.rz);
    tg_x[0] = (39'(item_q.ax) <<< 8) - sm_x[0];
    tg_x[1] = (39'(item_q.ay) <<< 8) - sm_x[1];
    tg_x[2] = (39'(item_q.az) <<< 8) - sm_x[2];
    wc_x    = (cfg_i.weight > 17'd65536) ? 39'sd65536 : $signed({22'd0, cfg_i.weight});
    beta_x  = $signed({23'd0, cfg_i.beta});
  end

  always_comb begin
    op_a_raw = '0;
    op_b_raw = '0;
    sh       = '0;
    neg      = 1'b0;
    first    = 1'b0;
    last     = 1'b0;
    dst      = '0;
    fin      = '0;
    k_last   = '0;
    nxt      = ST_IDLE;
    case (state_q)
      ST_LP: begin
        op_a_raw = wc_x;
        op_b_raw = tg_x[kk];
        sh       = 6'd16;
        k_last   = 4'd2;
        nxt      = item_q.held ? ST_OUT : ST_ASUM;
      end
      ST_ASUM: begin
        op_a_raw = sm_x[kk];
        op_b_raw = sm_x[kk];
        first    = (k_q == 4'd0);
        k_last   = 4'd2;
        nxt      = ST_ASQRT;
      end
      ST_ASQRT: nxt = ST_ADIV;
      ST_ADIV: begin
        k_last = 4'd2;
        nxt    = ST_F;
      end
      ST_F: begin
        sh     = 6'd30;
        k_last = 4'd5;
        nxt    = ST_G;
        case (k_q)
          4'd0: begin
            op_a_raw = tq_x[1]; op_b_raw = att_x[3]; first = 1'b1;
          end
          4'd1: begin
            op_a_raw = tq_x[0]; op_b_raw = att_x[2]; neg = 1'b1; last = 1'b1;
            dst = 2'd0; fin = -39'(av_q[0]);
          end
          4'd2: begin
            op_a_raw = tq_x[0]; op_b_raw = att_x[1]; first = 1'b1;
          end
          4'd3: begin
            op_a_raw = tq_x[2]; op_b_raw = att_x[3]; last = 1'b1;
            dst = 2'd1; fin = -39'(av_q[1]);
          end
          4'd4: begin
            op_a_raw = tq_x[1]; op_b_raw = att_x[1]; neg = 1'b1; first = 1'b1;
          end
          default: begin
            op_a_raw = tq_x[2]; op_b_raw = att_x[2]; neg = 1'b1; last = 1'b1;
            dst = 2'd2; fin = 39'sd1073741824 - 39'(av_q[2]);
          end
        endcase
      end
      ST_G: begin
        sh     = 6'd36;
        k_last = 4'd9;
        nxt    = ST_GSUM;
        case (k_q)
          4'd0: begin
            op_a_raw = tq_x[1]; op_b_raw = f_x[1]; first = 1'b1;
          end
          4'd1: begin
            op_a_raw = tq_x[2]; op_b_raw = f_x[0]; neg = 1'b1; last = 1'b1; dst = 2'd0;
          end
          4'd2: begin
            op_a_raw = tq_x[3]; op_b_raw = f_x[0]; first = 1'b1;
          end
          4'd3: begin
            op_a_raw = tq_x[0]; op_b_raw = f_x[1];
          end
          4'd4: begin
            op_a_raw = tq_x[1]; op_b_raw = f_x[2]; sh = 6'd35; neg = 1'b1;
            last = 1'b1; dst = 2'd1;
          end
          4'd5: begin
            op_a_raw = tq_x[3]; op_b_raw = f_x[1]; first = 1'b1;
          end
          4'd6: begin
            op_a_raw = tq_x[2]; op_b_raw = f_x[2]; sh = 6'd35; neg = 1'b1;
          end
          4'd7: begin
            op_a_raw = tq_x[0]; op_b_raw = f_x[0]; neg = 1'b1; last = 1'b1; dst = 2'd2;
          end
          4'd8: begin
            op_a_raw = tq_x[1]; op_b_raw = f_x[0]; first = 1'b1;
          end
          default: begin
            op_a_raw = tq_x[2]; op_b_raw = f_x[1]; last = 1'b1; dst = 2'd3;
          end
        endcase
      end
      ST_GSUM: begin
        op_a_raw = g_x[kk];
        op_b_raw = g_x[kk];
        first    = (k_q == 4'd0);
        k_last   = 4'd3;
        nxt      = ST_GSQRT;
      end
      ST_GSQRT: nxt = ST_GDIV;
      ST_GDIV: begin
        k_last = 4'd3;
        nxt    = ST_QD;
      end
      ST_QD: begin
        k_last = 4'd11;
        nxt    = ST_BG;
        case (k_q)
          4'd0: begin
            op_a_raw = att_x[1]; op_b_raw = rt_x[0]; neg = 1'b1; first = 1'b1;
          end
          4'd1: begin
            op_a_raw = att_x[2]; op_b_raw = rt_x[1]; neg = 1'b1;
          end
          4'd2: begin
            op_a_raw = att_x[3]; op_b_raw = rt_x[2]; neg = 1'b1; last = 1'b1; dst = 2'd0;
          end
          4'd3: begin
            op_a_raw = att_x[0]; op_b_raw = rt_x[0]; first = 1'b1;
          end
          4'd4: begin
            op_a_raw = att_x[2]; op_b_raw = rt_x[2];
          end
          4'd5: begin
            op_a_raw = att_x[3]; op_b_raw = rt_x[1]; neg = 1'b1; last = 1'b1; dst = 2'd1;
          end
          4'd6: begin
            op_a_raw = att_x[0]; op_b_raw = rt_x[1]; first = 1'b1;
          end
          4'd7: begin
            op_a_raw = att_x[1]; op_b_raw = rt_x[2]; neg = 1'b1;
          end
          4'd8: begin
            op_a_raw = att_x[3]; op_b_raw = rt_x[0]; last = 1'b1; dst = 2'd2;
          end
          4'd9: begin
            op_a_raw = att_x[0]; op_b_raw = rt_x[2]; first = 1'b1;
          end
          4'd10: begin
            op_a_raw = att_x[1]; op_b_raw = rt_x[1];
          end
          default: begin
            op_a_raw = att_x[2]; op_b_raw = rt_x[0]; neg = 1'b1; last = 1'b1; dst = 2'd3;
          end
        endcase
      end
      ST_BG: begin
        op_a_raw = beta_x;
        op_b_raw = g_x[kk];
        sh       = 6'd16;
        first    = 1'b1;
        last     = 1'b1;
        dst      = kk;
        k_last   = 4'd3;
        nxt      = ST_DT;
      end
      ST_DT: begin
        k_last = 4'd3;
        nxt    = ST_HALVE;
      end
      ST_QSUM: begin
        op_a_raw = qn_x[kk];
        op_b_raw = qn_x[kk];
        first    = (k_q == 4'd0);
        k_last   = 4'd3;
        nxt      = ST_QSQRT;
      end
      ST_QSQRT: nxt = ST_QDIV;
      ST_QDIV: begin
        k_last = 4'd3;
        nxt    = ST_OUT;
      end
      default: nxt = ST_IDLE;
    endcase
  end

  assign mul_p = 66'(clamp_op(op_a_raw)) * 66'(clamp_op(op_b_raw));
  assign dt_p  = 55'(qd_q[kk]) * 55'($signed({1'b0, cfg_i.dt}));
  assign term  = (prod_q + ((state_q == ST_LP) ? 66'sd32768 : 66'sd0)) >>> sh;
  assign acc_n = (first ? 67'sd0 : acc_q) + (neg ? -67'(term) : 67'(term));

  always_comb begin
    q_big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (qn_q[i] >= Lim39 || qn_q[i] <= -Lim39) begin
        q_big = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_ADIV: dv_v = sm_x[kk];
      ST_GDIV: dv_v = g_x[kk];
      default: dv_v = qn_x[kk];
    endcase
    dv_mag = dv_v[38] ? -dv_v : dv_v;
    dv_res = dv_v[38] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
  end

  assign in_div   = (state_q == ST_ADIV) || (state_q == ST_GDIV) || (state_q == ST_QDIV);
  assign sq_start = !ph_q && ((state_q == ST_ASQRT) || (state_q == ST_GSQRT) ||
                              (state_q == ST_QSQRT));
  assign dv_start = !ph_q && in_div && (nrm_q != 32'd0);

  iof_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (acc_q[63:0]),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  iof_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_mag[31:0]),
    .den_i  (nrm_q),
    .done_o (dv_done),
    .quo_o  (dv_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
      sm_q[0]     <= 24'sd0;
      sm_q[1]     <= 24'sd0;
      sm_q[2]     <= 24'sd1048576;
      att_q[0]    <= 32'sd1073741824;
      att_q[1]    <= 32'sd0;
      att_q[2]    <= 32'sd0;
      att_q[3]    <= 32'sd0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            item_q  <= item_i;
            state_q <= ST_LP;
            k_q     <= '0;
            ph_q    <= 1'b0;
          end
        end
        ST_LP, ST_ASUM, ST_F, ST_G, ST_GSUM, ST_QD, ST_BG, ST_QSUM: begin
          if (!ph_q) begin
            prod_q <= mul_p;
            ph_q   <= 1'b1;
          end else begin
            ph_q  <= 1'b0;
            acc_q <= acc_n;
            case (state_q)
              ST_LP: sm_q[kk] <= sm_q[kk] + term[23:0];
              ST_F: begin
                if (last) begin
                  f_q[dst] <= 36'(acc_n + 67'(fin));
                end
              end
              ST_G: begin
                if (last) begin
                  g_q[dst] <= 32'(acc_n);
                end
              end
              ST_QD: begin
                if (last) begin
                  qd_q[dst] <= 38'(acc_n >>> 12);
                end
              end
              ST_BG: qd_q[dst] <= qd_q[dst] - 38'(term);
              default: ;
            endcase
            if (k_q == k_last) begin
              state_q <= nxt;
              k_q     <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_DT: begin
          if (!ph_q) begin
            prod_dt_q <= dt_p;
            ph_q      <= 1'b1;
          end else begin
            ph_q     <= 1'b0;
            qn_q[kk] <= 39'(att_q[kk]) + 39'(prod_dt_q >>> 16);
            if (k_q == k_last) begin
              state_q <= nxt;
              k_q     <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_HALVE: begin
          if (q_big) begin
            for (int i = 0; i < 4; i++) begin
              qn_q[i] <= qn_q[i] >>> 1;
            end
          end else begin
            state_q <= ST_QSUM;
            k_q     <= '0;
          end
        end
        ST_ASQRT, ST_GSQRT, ST_QSQRT: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else if (sq_done) begin
            nrm_q   <= sq_root;
            ph_q    <= 1'b0;
            state_q <= nxt;
            k_q     <= '0;
          end
        end
        ST_ADIV, ST_GDIV, ST_QDIV: begin
          if (!ph_q && nrm_q == 32'd0) begin
            case (state_q)
              ST_ADIV: av_q[kk]  <= 32'(sm_q[kk]);
              ST_QDIV: att_q[kk] <= qn_q[kk][31:0];
              default: ;
            endcase
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end else if (dv_done) begin
            case (state_q)
              ST_ADIV: av_q[kk]  <= dv_res;
              ST_GDIV: g_q[kk]   <= dv_res;
              default: att_q[kk] <= dv_res;
            endcase
          end
          if ((!ph_q && nrm_q == 32'd0) || (ph_q && dv_done)) begin
            ph_q <= 1'b0;
            if (k_q == k_last) begin
              state_q <= nxt;
              k_q     <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            for (int i = 0; i < 4; i++) begin
              out_q[i] <= att_q[i];
            end
            out_held_q  <= item_q.held;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign item_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign quat_w_o      = out_q[0];
  assign quat_x_o      = out_q[1];
  assign quat_y_o      = out_q[2];
  assign quat_z_o      = out_q[3];
  assign held_static_o = out_held_q;

endmodule

### hw/rtl/imu_orientation_filter_unit.sv
// Top level of the IMU orientation filter: register port, front end, queue and engine.
// A static item (all rates in the deadband) skips the gradient step and renormalization;
// a moving item runs the three root runs and eleven divisions, and halves an oversized
// step as often as it needs. The engine takes a new item only once it is through with
// the last one; the queue holds two more items meanwhile.
// Reset: registers take their defaults, attitude is identity, filter holds (0, 0, 1 g).
`timescale 1ns / 1ps
module imu_orientation_filter_unit import iof_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] quat_w_o,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic               held_static_o
);

  iof_cfg_t  cfg_q;
  iof_reg_e  reg_idx;
  logic      reg_wr;
  logic      push_valid;
  logic      push_ready;
  iof_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  iof_item_t pop_item;

  assign reg_idx = iof_reg_e'(paddr[4:2]);
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_x    <= 16'sd0;
      cfg_q.off_y    <= 16'sd0;
      cfg_q.off_z    <= 16'sd0;
      cfg_q.deadband <= 15'd61;
      cfg_q.beta     <= 16'd9903;
      cfg_q.weight   <= 17'd6554;
      cfg_q.dt       <= 16'd655;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_GYRO_OFFSET_X:    cfg_q.off_x    <= pwdata[15:0];
        REG_GYRO_OFFSET_Y:    cfg_q.off_y    <= pwdata[15:0];
        REG_GYRO_OFFSET_Z:    cfg_q.off_z    <= pwdata[15:0];
        REG_RATE_DEADBAND:    cfg_q.deadband <= pwdata[14:0];
        REG_CORRECTION_GAIN:  cfg_q.beta     <= pwdata[15:0];
        REG_SMOOTHING_WEIGHT: cfg_q.weight   <= pwdata[16:0];
        REG_STEP_TIME:        cfg_q.dt       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GYRO_OFFSET_X:    prdata = 32'(cfg_q.off_x);
      REG_GYRO_OFFSET_Y:    prdata = 32'(cfg_q.off_y);
      REG_GYRO_OFFSET_Z:    prdata = 32'(cfg_q.off_z);
      REG_RATE_DEADBAND:    prdata = {17'd0, cfg_q.deadband};
      REG_CORRECTION_GAIN:  prdata = {16'd0, cfg_q.beta};
      REG_SMOOTHING_WEIGHT: prdata = {15'd0, cfg_q.weight};
      REG_STEP_TIME:        prdata = {16'd0, cfg_q.dt};
      default:              prdata = '0;
    endcase
  end

  iof_front u_front (
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .rate_x_i    (rate_x_i),
    .rate_y_i    (rate_y_i),
    .rate_z_i    (rate_z_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  iof_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  iof_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o),
    .held_static_o(held_static_o)
  );

endmodule

### sim/imu_orientation_filter_unit_tb.sv
// Self-checking testbench for the IMU orientation filter: random and directed samples.
`timescale 1ns / 1ps
module imu_orientation_filter_unit_tb;
  import iof_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az, rx, ry, rz;
  } sample_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               held;
  } attitude_t;

  localparam longint Q30 = 64'sd1 << 30;
  localparam longint OpLim = 64'sd1 << 31;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic held_static_o;

  imu_orientation_filter_unit DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sample_t   pending_samples[$];
  attitude_t expected_attitudes[$];
  int        mismatches = 0;
  int        results_seen = 0;
  bit        calm = 1'b0;

  longint off_x, off_y, off_z, deadband, beta, weight, dt;
  longint filt[3];
  longint att[4];

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint mul_shift(longint a, longint b, int sh);
    return (clip(a, OpLim) * clip(b, OpLim)) >>> sh;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void to_unit(inout longint v[4], input int n);
    longint unsigned sum, m, nr;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      sum = sum + m * m;
    end
    nr = root_floor(sum);
    if (nr != 0)
      for (int i = 0; i < n; i++) v[i] = (v[i] * Q30) / longint'(nr);
  endfunction

  function automatic void gradient_step(longint wx, longint wy, longint wz);
    longint a[4], g[4], q[4], qd[4];
    longint q1, q2, q3, q4, f1, f2, f3, j11, j12, j13, j14, d;
    bit big;
    for (int i = 0; i < 3; i++) a[i] = filt[i];
    a[3] = 0;
    to_unit(a, 3);
    q1 = att[0]; q2 = att[1]; q3 = att[2]; q4 = att[3];
    f1 = mul_shift(2 * q2, q4, 30) - mul_shift(2 * q1, q3, 30) - a[0];
    f2 = mul_shift(2 * q1, q2, 30) + mul_shift(2 * q3, q4, 30) - a[1];
    f3 = Q30 - mul_shift(2 * q2, q2, 30) - mul_shift(2 * q3, q3, 30) - a[2];
    j11 = 2 * q3; j12 = 2 * q4; j13 = 2 * q1; j14 = 2 * q2;
    g[0] = mul_shift(j14, f2, 36) - mul_shift(j11, f1, 36);
    g[1] = mul_shift(j12, f1, 36) + mul_shift(j13, f2, 36) - mul_shift(j14, f3, 35);
    g[2] = mul_shift(j12, f2, 36) - mul_shift(j11, f3, 35) - mul_shift(j13, f1, 36);
    g[3] = mul_shift(j14, f1, 36) + mul_shift(j11, f2, 36);
    to_unit(g, 4);
    qd[0] = (-(q2 * wx + q3 * wy + q4 * wz)) >>> 12;
    qd[1] = (q1 * wx + q3 * wz - q4 * wy) >>> 12;
    qd[2] = (q1 * wy - q2 * wz + q4 * wx) >>> 12;
    qd[3] = (q1 * wz + q2 * wy - q3 * wx) >>> 12;
    for (int i = 0; i < 4; i++) begin
      d = qd[i] - ((beta * g[i]) >>> 16);
      q[i] = att[i] + ((d * dt) >>> 16);
    end
    do begin
      big = 1'b0;
      for (int i = 0; i < 4; i++) if (q[i] >= OpLim || q[i] <= -OpLim) big = 1'b1;
      if (big) for (int i = 0; i < 4; i++) q[i] = q[i] >>> 1;
    end while (big);
    to_unit(q, 4);
    for (int i = 0; i < 4; i++) att[i] = clip(q[i], Q30);
  endfunction

  function automatic attitude_t predict_attitude(sample_t s);
    longint acc[3], r[3], offs[3], wt, tgt;
    attitude_t res;
    acc[0] = s.ax; acc[1] = s.ay; acc[2] = s.az;
    r[0] = s.rx; r[1] = s.ry; r[2] = s.rz;
    offs[0] = off_x; offs[1] = off_y; offs[2] = off_z;
    wt = weight > 65536 ? 65536 : weight;
    for (int i = 0; i < 3; i++) begin
      tgt = acc[i] * 256;
      filt[i] = filt[i] + ((wt * (tgt - filt[i]) + 32768) >>> 16);
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = r[i] - offs[i];
      if ((r[i] < 0 ? -r[i] : r[i]) < deadband) r[i] = 0;
    end
    res.held = (r[0] == 0 && r[1] == 0 && r[2] == 0);
    if (!res.held) gradient_step(r[0], r[1], r[2]);
    res.w = att[0]; res.x = att[1]; res.y = att[2]; res.z = att[3];
    return res;
  endfunction

  // Sender: hold until accepted, then advance
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s.ax = accel_x_i; s.ay = accel_y_i; s.az = accel_z_i;
        s.rx = rate_x_i; s.ry = rate_y_i; s.rz = rate_z_i;
        expected_attitudes.push_back(predict_attitude(s));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
          s = pending_samples.pop_front();
          accel_x_i <= s.ax; accel_y_i <= s.ay; accel_z_i <= s.az;
          rate_x_i <= s.rx; rate_y_i <= s.ry; rate_z_i <= s.rz;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check against the oldest prediction
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_attitudes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: w=%0d", quat_w_o);
        end else begin
          e = expected_attitudes.pop_front();
          if (e.w !== quat_w_o || e.x !== quat_x_o || e.y !== quat_y_o ||
              e.z !== quat_z_o || e.held !== held_static_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.w, e.x, e.y, e.z, e.held,
                       quat_w_o, quat_x_o, quat_y_o, quat_z_o, held_static_o);
          end
        end
      end
      if (!hold_done && results_seen == 100) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(99) >= 37;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IdleLimit) begin
      $display("imu_orientation_filter_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(iof_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_GYRO_OFFSET_X:    off_x = longint'($signed(v[15:0]));
      REG_GYRO_OFFSET_Y:    off_y = longint'($signed(v[15:0]));
      REG_GYRO_OFFSET_Z:    off_z = longint'($signed(v[15:0]));
      REG_RATE_DEADBAND:    deadband = v[14:0];
      REG_CORRECTION_GAIN:  beta = v[15:0];
      REG_SMOOTHING_WEIGHT: weight = v[16:0];
      REG_STEP_TIME:        dt = v[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(int ox, int oy, int oz, int db, int gain, int wt, int st);
    write_reg(REG_GYRO_OFFSET_X, ox);
    write_reg(REG_GYRO_OFFSET_Y, oy);
    write_reg(REG_GYRO_OFFSET_Z, oz);
    write_reg(REG_RATE_DEADBAND, db);
    write_reg(REG_CORRECTION_GAIN, gain);
    write_reg(REG_SMOOTHING_WEIGHT, wt);
    write_reg(REG_STEP_TIME, st);
  endtask

  task automatic add_sample(int ax, int ay, int az, int rx, int ry, int rz);
    sample_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.rx = rx; s.ry = ry; s.rz = rz;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70)
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (k < 85)
        add_sample($urandom, $urandom, $urandom,
                   off_x + $urandom_range(2) - 1, off_y + $urandom_range(2) - 1,
                   off_z + $urandom_range(2) - 1);
      else
        add_sample($urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 32767 : -32768,
                   $urandom_range(1) ? 4096 : -4096, $urandom_range(1) ? 32767 : -32768,
                   $urandom_range(300) - 150, $urandom_range(1) ? 32767 : -32768);
    end
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_attitudes.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    off_x = 0; off_y = 0; off_z = 0;
    deadband = 61; beta = 9903; weight = 6554; dt = 655;
    filt[0] = 0; filt[1] = 0; filt[2] = 64'sd1 << 20;
    att[0] = Q30; att[1] = 0; att[2] = 0; att[3] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    add_sample(0, 0, 4096, 0, 0, 0);
    add_sample(0, 0, 4096, 100, 0, 0);
    add_sample(0, 0, 4096, 60, -60, 60);
    add_sample(0, 0, 4096, 61, 0, -61);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    add_sample(32767, -32768, 0, -32768, 32767, 0);
    add_sample(0, 0, 0, 0, 0, 500);
    add_sample(1, -1, 1, -1, 1, -1);
    add_sample(4096, 0, 0, 0, 2000, 0);
    add_random(90);
    drain();

    configure(100, -200, 300, 0, 65535, 65536, 65535);
    add_sample(0, 0, 0, 1000, 0, 0);
    add_sample(0, 0, 0, 0, 2000, 0);
    add_sample(0, 0, 0, 100, -200, 300);
    add_sample(0, 0, 0, 101, -200, 300);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767);
    add_random(100);
    drain();

    configure(32767, -32768, -32768, 32767, 0, 0, 1);
    add_sample(0, 0, 0, -32768, 32767, 32767);
    add_sample(32767, 32767, 32767, 32767, -32768, -32768);
    add_random(100);
    drain();

    configure(0, 0, 0, 61, 9903, 131071, 0);
    add_sample(0, 0, 4096, 5000, 5000, 5000);
    add_random(90);
    drain();

    configure($urandom, $urandom, $urandom, $urandom_range(32767), $urandom_range(65535),
              $urandom_range(131071), $urandom_range(65535, 1));
    add_random(100);
    drain();

    calm = 1'b1;
    configure(-5, 7, -3, 61, 9903, 6554, 655);
    add_random(80);
    drain();
    calm = 1'b0;
    add_random(60);
    drain();

    repeat (700) @(posedge clk_i);
    if (mismatches == 0 && expected_attitudes.size() == 0)
      $display("imu_orientation_filter_unit_tb: PASS");
    else
      $display("imu_orientation_filter_unit_tb: FAIL");
    $finish;
  end

endmodule
